// ===== hdl/mlfp_pkg.sv =====
package mlfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 10;
    localparam int WIDE_W  = 16;

    // Frame header magic, first byte first
    localparam logic [BYTE_W-1:0] MAGIC [4] = '{8'h41, 8'h43, 8'h4D, 8'h31};

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 10'd320;

    // Input register contents handed to the parser
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
    } t_stage;

    // One result item
    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  payload_index;
        logic              frame_done;
        logic              awaiting_flag;
        logic [LEN_W-1:0]  frame_length;
        logic              length_error;
    } t_result;

endpackage

// ===== hdl/mlfp_if.sv =====
interface mlfp_byte_if import mlfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface mlfp_cfg_if import mlfp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] max_length;

    modport source (output valid, output max_length, input ready);
    modport sink   (input valid, input max_length, output ready);
endinterface

interface mlfp_result_if import mlfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  payload_index;
    logic              frame_done;
    logic              awaiting_flag;
    logic [LEN_W-1:0]  frame_length;
    logic              length_error;

    modport source (
        output valid, output payload_valid, output payload_byte, output payload_index,
        output frame_done, output awaiting_flag, output frame_length, output length_error,
        input  ready
    );
    modport sink (
        input  valid, input payload_valid, input payload_byte, input payload_index,
        input  frame_done, input awaiting_flag, input frame_length, input length_error,
        output ready
    );
endinterface

// ===== hdl/mlfp_in_stage.sv =====
module mlfp_in_stage import mlfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlfp_byte_if.sink   i_in,
    input  logic        i_take,
    output t_stage      o_stage
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;

    // Accept when empty or when the held item moves on this cycle
    assign i_in.ready = !r_valid || i_take;

    // Hold one received byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
        if (i_in.valid && i_in.ready) begin
            r_data <= i_in.data_byte;
        end
    end

    assign o_stage.valid     = r_valid;
    assign o_stage.data_byte = r_data;

endmodule

// ===== hdl/mlfp_parser.sv =====
module mlfp_parser import mlfp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_stage        i_stage,
    output logic          o_take,
    mlfp_cfg_if.sink      i_cfg,
    mlfp_result_if.source o_out
);

    typedef enum logic [2:0] {
        ST_MAGIC0  = 3'd0,
        ST_MAGIC1  = 3'd1,
        ST_MAGIC2  = 3'd2,
        ST_MAGIC3  = 3'd3,
        ST_FLAG    = 3'd4,
        ST_LEN_LO  = 3'd5,
        ST_LEN_HI  = 3'd6,
        ST_PAYLOAD = 3'd7
    } t_state;

    t_state            r_state,    n_state;
    logic              r_awaiting, n_awaiting;
    logic [BYTE_W-1:0] r_len_lo,   n_len_lo;
    logic [LEN_W-1:0]  r_expected, n_expected;
    logic [LEN_W-1:0]  r_count,    n_count;
    logic [LEN_W-1:0]  r_max;
    logic              r_out_valid;
    t_result           r_res,      n_res;

    logic [2:0]        w_pos;
    logic [WIDE_W-1:0] w_len;
    logic [LEN_W-1:0]  w_count_inc;

    // Move the held byte through when the result register is free
    assign o_take    = i_stage.valid && (!r_out_valid || o_out.ready);
    assign i_cfg.ready = 1'b1;

    assign w_pos       = r_state;
    assign w_len       = {i_stage.data_byte, r_len_lo};
    assign w_count_inc = r_count + 10'd1;

    // Next state and result for the held byte
    always_comb begin
        n_state    = r_state;
        n_awaiting = r_awaiting;
        n_len_lo   = r_len_lo;
        n_expected = r_expected;
        n_count    = r_count;
        n_res      = '0;
        case (r_state)
            ST_MAGIC0, ST_MAGIC1, ST_MAGIC2, ST_MAGIC3: begin
                if (i_stage.data_byte == MAGIC[w_pos[1:0]]) begin
                    n_state = t_state'(w_pos + 3'd1);
                end else if (i_stage.data_byte == MAGIC[0]) begin
                    n_state = ST_MAGIC1;
                end else begin
                    n_state = ST_MAGIC0;
                end
            end
            ST_FLAG: begin
                n_awaiting = (i_stage.data_byte != '0);
                n_state    = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                n_len_lo = i_stage.data_byte;
                n_state  = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                if (w_len > {{(WIDE_W-LEN_W){1'b0}}, r_max}) begin
                    // Drop oversized frame
                    n_res.length_error = 1'b1;
                    n_state    = ST_MAGIC0;
                    n_expected = '0;
                    n_count    = '0;
                end else if (w_len == '0) begin
                    // Empty frame completes at once
                    n_res.frame_done = 1'b1;
                    n_state    = ST_MAGIC0;
                    n_expected = '0;
                    n_count    = '0;
                end else begin
                    n_expected = w_len[LEN_W-1:0];
                    n_count    = '0;
                    n_state    = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                n_res.payload_valid = 1'b1;
                n_res.payload_byte  = i_stage.data_byte;
                n_res.payload_index = r_count;
                n_count             = w_count_inc;
                if (w_count_inc == r_expected) begin
                    n_res.frame_done   = 1'b1;
                    n_res.frame_length = r_expected;
                    n_state    = ST_MAGIC0;
                    n_expected = '0;
                    n_count    = '0;
                end
            end
            default: begin
                n_state = ST_MAGIC0;
            end
        endcase
        n_res.awaiting_flag = n_awaiting;
    end

    // Hold parser state, limit register and the result item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_MAGIC0;
            r_awaiting  <= 1'b1;
            r_len_lo    <= '0;
            r_expected  <= '0;
            r_count     <= '0;
            r_max       <= MAX_LENGTH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_max <= i_cfg.max_length;
            end
            if (o_take) begin
                r_state     <= n_state;
                r_awaiting  <= n_awaiting;
                r_len_lo    <= n_len_lo;
                r_expected  <= n_expected;
                r_count     <= n_count;
                r_res       <= n_res;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.payload_valid = r_res.payload_valid;
    assign o_out.payload_byte  = r_res.payload_byte;
    assign o_out.payload_index = r_res.payload_index;
    assign o_out.frame_done    = r_res.frame_done;
    assign o_out.awaiting_flag = r_res.awaiting_flag;
    assign o_out.frame_length  = r_res.frame_length;
    assign o_out.length_error  = r_res.length_error;

    // A dropped frame never reports completion or payload
    a_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.length_error |-> !r_res.frame_done && !r_res.payload_valid)
        else $error("length error together with done or payload");

    // A frame ending on a payload byte reports its length as index plus one
    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.frame_done && r_res.payload_valid |->
            r_res.frame_length == 10'(r_res.payload_index + 10'd1))
        else $error("frame length does not match last index");

    // Parser state moves only with an item
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_take |=> $stable(r_state) && $stable(r_count) && $stable(r_awaiting))
        else $error("parser state changed without an item");

    // Payload index stays below the stored length
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PAYLOAD |-> r_count < r_expected)
        else $error("payload count reached stored length");

endmodule

// ===== hdl/magic_length_frame_parser.sv =====
// Frame parser for a received byte stream: hunts the magic header "ACM1", reads a flag
// byte and a 16-bit little-endian length, then passes each payload byte out with its
// index and marks the last one as frame end. Lengths above max_length drop the frame
// and report length_error. Every input item gives exactly one result item. One item
// is taken per clock cycle while the result side does not stall. Each byte is held
// first in the input register and then in the result register until it is taken.
// The header and counter update for a byte fits between the two. Backpressure on
// the result side stalls the input only once both registers hold an item. The
// max_length register is always ready and should be written only while no item is
// in flight.
module magic_length_frame_parser import mlfp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mlfp_byte_if.sink     i_in,
    mlfp_cfg_if.sink      i_cfg,
    mlfp_result_if.source o_out
);

    t_stage w_stage;
    logic   w_take;

    // Input register
    mlfp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_stage (w_stage)
    );

    // Header tracking, payload counting and result register
    mlfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_stage),
        .o_take  (w_take),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule
